// ===== rtl/aged_duplicate_filter_defines.svh =====
// assertion macros shared by the filter rtl
`ifndef AGED_DUPLICATE_FILTER_DEFINES_SVH
`define AGED_DUPLICATE_FILTER_DEFINES_SVH

// same-cycle implication, off during reset
`define ADF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define ADF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/adf_pkg.sv =====
package adf_pkg;

  localparam int DEPTH      = 32;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);
  localparam int HASH_W     = 16;
  localparam int STAMP_W    = 16;
  localparam int LIVE_OUT_W = 6;

  typedef enum logic [1:0] {
    OP_TICK         = 2'd0,
    OP_CHECK_INSERT = 2'd1,
    OP_LOOKUP       = 2'd2,
    OP_INSERT       = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [HASH_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic                  found;
    logic [LIVE_OUT_W-1:0] live_count;
  } out_rsp_t;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic expired;
  } cmp_res_t;

  // low bits of the live count as reported on the result port
  function automatic logic [LIVE_OUT_W-1:0] to_live_out(input logic [COUNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[LIVE_OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/aged_duplicate_filter.sv =====
// Duplicate filter over a ring of the last DEPTH packet hashes, each stamped
// with the tick at which it was stored. A request is taken when start is high
// and busy is low; busy then stays high until the request is done. Every
// request gives exactly one result, shown for one cycle with out_strobe high;
// the receiver cannot stall, so it must take the result in that cycle. A
// request goes through an accept step, then a walk over the ring entries by
// the shared compare unit (a lookup stops at the first hit, a tick at the
// first young entry, else the walk runs on past the last live entry), then
// a finish step; an insert only request skips the walk. The walk goes over
// the single read port of the ring memory, so a new request is taken only
// once busy falls. The result appears in the cycle after the finish step,
// when the next request may already be taken. Writes to max_age are taken
// at any cycle with cfg_we high and should be made while the block is idle.
`include "aged_duplicate_filter_defines.svh"

module aged_duplicate_filter
  import adf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_req_t             in_req,
  output logic                out_strobe,
  output out_rsp_t            out_rsp,
  input  logic                cfg_we,
  input  logic [STAMP_W-1:0]  cfg_wdata
);

  localparam int SUM_W = SLOT_W + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  // sequencer state
  state_t              state_r,      state_nxt;
  op_t                 op_r,         op_nxt;
  logic [HASH_W-1:0]   value_r,      value_nxt;
  logic [SLOT_W-1:0]   pos_r,        pos_nxt;
  logic [COUNT_W-1:0]  rem_r,        rem_nxt;
  logic                found_r,      found_nxt;

  // filter state
  logic [STAMP_W-1:0]  tick_r,       tick_nxt;
  logic [COUNT_W-1:0]  live_r,       live_nxt;
  logic [SLOT_W-1:0]   wslot_r,      wslot_nxt;
  logic [STAMP_W-1:0]  max_age_r,    max_age_nxt;

  // result register
  logic                out_strobe_r, out_strobe_nxt;
  out_rsp_t            out_rsp_r,    out_rsp_nxt;

  // ring and compare unit hookup
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  entry_t              ram_wdata;
  logic [SLOT_W-1:0]   ram_raddr;
  entry_t              ram_rdata;
  cmp_res_t            cmp_res;

  // slot arithmetic
  logic [COUNT_W-1:0]  live_mod;
  logic [SUM_W-1:0]    oldest_sum;
  logic [SUM_W-1:0]    oldest_red;
  logic [SLOT_W-1:0]   oldest;
  logic [SLOT_W-1:0]   pos_inc;
  logic [SLOT_W-1:0]   wslot_inc;

  adf_ring u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // one compare unit, reused for every entry of the walk
  adf_cmp u_cmp (
    .entry   (ram_rdata),
    .key     (value_r),
    .now     (tick_r),
    .max_age (max_age_r),
    .res     (cmp_res)
  );

  // oldest live slot: write slot minus live count, modulo DEPTH
  // (a full ring has its oldest entry at the write slot)
  assign live_mod   = (live_r == COUNT_W'(DEPTH)) ? '0 : live_r;
  assign oldest_sum = SUM_W'(wslot_r) + SUM_W'(DEPTH) - SUM_W'(live_mod);
  assign oldest_red = (oldest_sum >= SUM_W'(DEPTH)) ? oldest_sum - SUM_W'(DEPTH)
                                                    : oldest_sum;
  assign oldest     = oldest_red[SLOT_W-1:0];

  assign pos_inc   = (pos_r == SLOT_W'(DEPTH - 1)) ? '0 : pos_r + 1'b1;
  assign wslot_inc = (wslot_r == SLOT_W'(DEPTH - 1)) ? '0 : wslot_r + 1'b1;

  // read one entry ahead: the accept cycle fetches the oldest slot, each
  // walk cycle fetches the slot after the one being compared
  assign ram_raddr = (state_r == S_IDLE) ? oldest : pos_inc;
  assign ram_waddr = wslot_r;
  assign ram_wdata = '{hash: value_r, stamp: tick_r};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    value_nxt      = value_r;
    pos_nxt        = pos_r;
    rem_nxt        = rem_r;
    found_nxt      = found_r;
    tick_nxt       = tick_r;
    live_nxt       = live_r;
    wslot_nxt      = wslot_r;
    max_age_nxt    = cfg_we ? cfg_wdata : max_age_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    ram_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_req.op;
          value_nxt = in_req.value;
          pos_nxt   = oldest;
          rem_nxt   = live_r;
          found_nxt = 1'b0;
          // time advances before any age is checked
          if (in_req.op == OP_TICK) begin
            tick_nxt = tick_r + 1'b1;
          end
          state_nxt = (in_req.op == OP_INSERT) ? S_FIN : S_SCAN;
        end
      end

      S_SCAN: begin
        if (op_r == OP_TICK) begin
          // expire oldest first, stop at the first young entry
          if (live_r == '0 || !cmp_res.expired) begin
            state_nxt = S_FIN;
          end else begin
            live_nxt = live_r - 1'b1;
            pos_nxt  = pos_inc;
          end
        end else begin
          // lookup over the live entries, stop at the first hit
          if (rem_r == '0) begin
            state_nxt = S_FIN;
          end else if (cmp_res.hit) begin
            found_nxt = 1'b1;
            state_nxt = S_FIN;
          end else begin
            rem_nxt = rem_r - 1'b1;
            pos_nxt = pos_inc;
          end
        end
      end

      S_FIN: begin
        if (op_r == OP_CHECK_INSERT || op_r == OP_INSERT) begin
          // overwrite at the write slot; a full ring drops its oldest entry
          ram_we    = 1'b1;
          wslot_nxt = wslot_inc;
          if (live_r < COUNT_W'(DEPTH)) begin
            live_nxt = live_r + 1'b1;
          end
        end
        out_strobe_nxt         = 1'b1;
        out_rsp_nxt.found      = found_r;
        out_rsp_nxt.live_count = to_live_out(live_nxt);
        state_nxt              = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tick_r       <= '0;
      live_r       <= '0;
      wslot_r      <= '0;
      max_age_r    <= STAMP_W'(6);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_r       <= tick_nxt;
      live_r       <= live_nxt;
      wslot_r      <= wslot_nxt;
      max_age_r    <= max_age_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    // payload, no reset needed
    op_r      <= op_nxt;
    value_r   <= value_nxt;
    pos_r     <= pos_nxt;
    rem_r     <= rem_nxt;
    found_r   <= found_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  // checks
  `ADF_ASSERT_NOW(a_live_bound, clk, rst_n, 1'b1, live_r <= COUNT_W'(DEPTH), "live count above ring depth")
  `ADF_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted request did not raise busy")
  `ADF_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_strobe, !busy, "result shown while a request is still at work")
  `ADF_ASSERT_NEXT(a_tick_no_grow, clk, rst_n, state_r == S_SCAN && op_r == OP_TICK, live_r <= $past(live_r), "tick raised the live count")

endmodule

// ===== rtl/adf_ring.sv =====
module adf_ring
  import adf_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic [SLOT_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/adf_cmp.sv =====
module adf_cmp
  import adf_pkg::*;
(
  input  entry_t             entry,
  input  logic [HASH_W-1:0]  key,
  input  logic [STAMP_W-1:0] now,
  input  logic [STAMP_W-1:0] max_age,
  output cmp_res_t           res
);

  logic [STAMP_W-1:0] age;

  // age wraps with the 16-bit time counter
  assign age         = now - entry.stamp;
  assign res.hit     = (entry.hash == key);
  assign res.expired = (age > max_age);

endmodule

// ===== dv/dup_filter_checker.sv =====
module dup_filter_checker
  import adf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  in_req_t            in_req,
  input  logic               out_strobe,
  input  out_rsp_t           out_rsp,
  input  logic               cfg_we,
  input  logic [STAMP_W-1:0] cfg_wdata,
  output int                 awaited_cnt,
  output int                 mismatch_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirror of the ring
  logic [HASH_W-1:0]  hash_mem [DEPTH];
  logic [STAMP_W-1:0] stamp_mem[DEPTH];
  int unsigned        wr_slot;
  int unsigned        live_n;
  logic [STAMP_W-1:0] now_tick;
  logic [STAMP_W-1:0] age_limit;

  out_rsp_t awaited_rsp[$];
  out_rsp_t due;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] mismatch %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_cnt++;
  endtask

  function automatic int unsigned oldest_slot();
    return (wr_slot + DEPTH - (live_n % DEPTH)) % DEPTH;
  endfunction

  function automatic logic ring_holds(input logic [HASH_W-1:0] v);
    int unsigned pos;
    logic hit;
    pos = oldest_slot();
    hit = 1'b0;
    for (int unsigned k = 0; k < live_n && k < DEPTH; k++) begin
      if (hash_mem[pos[SLOT_W-1:0]] == v) hit = 1'b1;
      pos = (pos + 1) % DEPTH;
    end
    return hit;
  endfunction

  function automatic void ring_store(input logic [HASH_W-1:0] v);
    hash_mem[wr_slot[SLOT_W-1:0]]  = v;
    stamp_mem[wr_slot[SLOT_W-1:0]] = now_tick;
    wr_slot = (wr_slot + 1) % DEPTH;
    if (live_n < DEPTH) live_n++;
  endfunction

  // one request applied to the mirror, giving the result it should produce
  function automatic out_rsp_t filter_predict(input in_req_t req);
    out_rsp_t rsp;
    int unsigned pos;
    logic [STAMP_W-1:0] age;
    logic young;
    rsp.found = 1'b0;
    case (req.op)
      OP_TICK: begin
        now_tick = now_tick + 1'b1;
        pos = oldest_slot();
        young = 1'b0;
        // expire from the oldest end, stop at the first young entry
        while (live_n > 0 && !young) begin
          age = now_tick - stamp_mem[pos[SLOT_W-1:0]];
          if (age <= age_limit) begin
            young = 1'b1;
          end else begin
            live_n--;
            pos = (pos + 1) % DEPTH;
          end
        end
      end
      OP_CHECK_INSERT: begin
        rsp.found = ring_holds(req.value);
        ring_store(req.value);
      end
      OP_LOOKUP: begin
        rsp.found = ring_holds(req.value);
      end
      default: begin
        ring_store(req.value);
      end
    endcase
    rsp.live_count = LIVE_OUT_W'(live_n);
    return rsp;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wr_slot      = 0;
      live_n       = 0;
      now_tick     = '0;
      age_limit    = 16'd6;
      mismatch_cnt = 0;
      awaited_rsp.delete();
    end else begin
      if (out_strobe) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("unexpected result", 0, 1);
        end else begin
          due = awaited_rsp.pop_front();
          if (out_rsp.found !== due.found)
            report_mismatch("found", 32'(due.found), 32'(out_rsp.found));
          if (out_rsp.live_count !== due.live_count)
            report_mismatch("live_count", 32'(due.live_count),
                            32'(out_rsp.live_count));
        end
      end
      if (cfg_we) age_limit = cfg_wdata;
      if (start && !busy) awaited_rsp.push_back(filter_predict(in_req));
    end
    awaited_cnt <= awaited_rsp.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import adf_pkg::*;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  in_req_t            in_req    = '0;
  logic               cfg_we    = 1'b0;
  logic [STAMP_W-1:0] cfg_wdata = '0;
  logic               busy;
  logic               out_strobe;
  out_rsp_t           out_rsp;
  int                 awaited_cnt;
  int                 mismatches;

  // recently inserted hashes, reused so lookups actually hit
  logic [HASH_W-1:0]  recent_vals[8] = '{default: '0};
  int unsigned        recent_wr = 0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  aged_duplicate_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  dup_filter_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req       (in_req),
    .out_strobe   (out_strobe),
    .out_rsp      (out_rsp),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .awaited_cnt  (awaited_cnt),
    .mismatch_cnt (mismatches)
  );

  // present one request and hold it until the block takes it;
  // start is left high so the next request can follow back to back
  task automatic send_req(input op_t op, input logic [HASH_W-1:0] v);
    in_req_t req;
    req.op    = op;
    req.value = v;
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_CHECK_INSERT || op == OP_INSERT) begin
      recent_vals[recent_wr[2:0]] = v;
      recent_wr = (recent_wr + 1) % 8;
    end
  endtask

  task automatic idle_gap(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result
  // the extra edge lets the checker count the last accepted request
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_cnt != 0) @(posedge clk);
  endtask

  // max_age only changes with the block idle
  task automatic write_max_age(input logic [STAMP_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // bursts of random requests; tick_pct sets how fast entries age out
  task automatic random_run(input int unsigned n, input int unsigned tick_pct);
    int unsigned left;
    int unsigned burst;
    op_t op;
    logic [HASH_W-1:0] v;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        if ($urandom_range(0, 99) < tick_pct) begin
          op = OP_TICK;
        end else begin
          case ($urandom_range(0, 2))
            0:       op = OP_CHECK_INSERT;
            1:       op = OP_LOOKUP;
            default: op = OP_INSERT;
          endcase
        end
        // mostly known hashes so duplicates are common, rest fully random
        if ($urandom_range(0, 99) < 60)
          v = recent_vals[3'($urandom_range(0, 7))];
        else
          v = 16'($urandom_range(0, 65535));
        send_req(op, v);
        burst--;
        left--;
      end
      // gap between bursts: none, a short pause, or a full drain
      case ($urandom_range(0, 29))
        0:                          drain();
        1, 2, 3, 4, 5, 6, 7, 8, 9:  ;
        default:                    idle_gap($urandom_range(1, 12));
      endcase
    end
  endtask

  // watchdog well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty ring, both hash extremes, hit and miss, expiry at reset max_age
    send_req(OP_LOOKUP,       16'h0000);
    send_req(OP_TICK,         16'hFFFF);
    send_req(OP_INSERT,       16'h0000);
    send_req(OP_INSERT,       16'hFFFF);
    send_req(OP_CHECK_INSERT, 16'hFFFF);
    send_req(OP_LOOKUP,       16'h0000);
    idle_gap(3);
    send_req(OP_LOOKUP,       16'h1234);
    send_req(OP_CHECK_INSERT, 16'h5A5A);
    send_req(OP_INSERT,       16'hA5A5);
    repeat (7) send_req(OP_TICK, 16'h0000);
    send_req(OP_LOOKUP,       16'hFFFF);
    send_req(OP_CHECK_INSERT, 16'hFFFF);
    send_req(OP_LOOKUP,       16'hFFFF);

    // random phases over several max_age settings, extremes included
    random_run(150, 15);
    write_max_age(16'd0);
    random_run(120, 20);
    write_max_age(16'hFFFF);
    random_run(200, 5);
    write_max_age(16'd3);
    random_run(150, 15);
    write_max_age(16'd20);
    random_run(150, 10);
    write_max_age(16'($urandom_range(0, 40)));
    random_run(150, 12);

    // short max_age with frequent ticks
    write_max_age(16'd5);
    random_run(120, 40);

    drain();
    repeat (DEPTH + 4) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/adf_pkg.sv
rtl/adf_ring.sv
rtl/adf_cmp.sv
rtl/aged_duplicate_filter.sv
dv/dup_filter_checker.sv
dv/testbench.sv
